>>> design/clmd_pkg.sv
package clmd_pkg;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_COUNT  = 6;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_FRAME_WIDTH     = 3'd0,
    CFG_FRAME_HEIGHT    = 3'd1,
    CFG_KERNEL_SIZE     = 3'd2,
    CFG_COLOR_THRESHOLD = 3'd3,
    CFG_GRAY_THRESHOLD  = 3'd4,
    CFG_TARGET_BLUE     = 3'd5
  } cfg_idx_t;

  localparam logic [10:0] RST_FRAME_WIDTH  = 11'd640;
  localparam logic [10:0] RST_FRAME_HEIGHT = 11'd480;
  localparam logic [3:0]  RST_KERNEL_SIZE  = 4'd11;
  localparam logic [7:0]  RST_COLOR_THR    = 8'd150;
  localparam logic [7:0]  RST_GRAY_THR     = 8'd150;
  localparam logic        RST_TARGET_BLUE  = 1'b1;

  localparam logic [22:0] LUMA_B     = 23'd1868;
  localparam logic [22:0] LUMA_G     = 23'd9617;
  localparam logic [22:0] LUMA_R     = 23'd4899;
  localparam logic [22:0] LUMA_ROUND = 23'd8192;
  localparam int          LUMA_SHIFT = 14;

  localparam int S_TDATA_W  = 24;
  localparam int M_TDATA_W  = 8;
  localparam int FIFO_DEPTH = 3;

  typedef struct packed {
    logic color;
    logic gray;
    logic seed;
  } cm_req_t;

  typedef struct packed {
    logic vhit;
    logic own_color;
    logic own_gray;
  } cm_rsp_t;

  typedef struct packed {
    logic [1:0] count;
  } fifo_stat_t;

  typedef struct packed {
    logic mask_bit;
    logic frame_end;
  } out_item_t;

endpackage

>>> design/clmd_column_mem.sv
module clmd_column_mem #(
  parameter int DEPTH   = 1024,
  parameter int RW      = 11,
  parameter int KW      = 4,
  parameter int EXT_MAX = 7
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  input  clmd_pkg::cm_req_t        req,
  input  logic [RW-1:0]            row,
  input  logic [KW-1:0]            k_eff,
  input  logic [KW-1:0]            ext,
  output clmd_pkg::cm_rsp_t        rsp,
  output logic                     clearing
);

  localparam int AW  = $clog2(DEPTH);
  localparam int DW  = (EXT_MAX > 0) ? 2 * EXT_MAX : 2;
  localparam logic [KW-1:0] SAT = {KW{1'b1}};

  logic [KW-1:0] age_mem [DEPTH];
  logic [DW-1:0] dly_mem [DEPTH];

  logic [KW-1:0]     age_rd;
  logic [DW-1:0]     dly_rd;
  logic              fwd;
  logic [KW-1:0]     fwd_age;
  logic [DW-1:0]     fwd_dly;
  logic              s1_valid;
  logic [AW-1:0]     s1_addr;
  clmd_pkg::cm_req_t s1_req;
  logic [RW-1:0]     s1_row;
  logic [AW-1:0]     clr_addr;

  logic [KW-1:0] age_q;
  logic [DW-1:0] dly_q;
  logic [KW-1:0] age_new;
  logic [DW-1:0] dly_new;

  always_comb begin
    age_q = fwd ? fwd_age : age_rd;
    dly_q = fwd ? fwd_dly : dly_rd;
    if (s1_req.seed) begin
      age_new = '0;
    end else if (age_q == SAT) begin
      age_new = SAT;
    end else begin
      age_new = age_q + KW'(1);
    end
    dly_new = DW'({dly_q, s1_req.color, s1_req.gray});
    rsp.vhit = (32'(age_new) < 32'(k_eff)) && (32'(age_new) <= 32'(s1_row));
    rsp.own_color = s1_req.color;
    rsp.own_gray  = s1_req.gray;
    for (int i = 0; i < EXT_MAX; i++) begin
      if (32'(ext) == i + 1) begin
        rsp.own_color = dly_q[2*i+1];
        rsp.own_gray  = dly_q[2*i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fwd      <= 1'b0;
      clearing <= 1'b1;
      clr_addr <= '0;
    end else begin
      s1_valid <= rd_en;
      if (rd_en) begin
        fwd <= s1_valid && (s1_addr == rd_addr);
      end
      if (clearing) begin
        clr_addr <= clr_addr + AW'(1);
        if (32'(clr_addr) == DEPTH - 1) begin
          clearing <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      s1_addr <= rd_addr;
      s1_req  <= req;
      s1_row  <= row;
      fwd_age <= age_new;
      fwd_dly <= dly_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      age_rd <= age_mem[rd_addr];
      dly_rd <= dly_mem[rd_addr];
    end
    if (clearing) begin
      age_mem[clr_addr] <= SAT;
    end else if (s1_valid) begin
      age_mem[s1_addr] <= age_new;
      dly_mem[s1_addr] <= dly_new;
    end
  end

endmodule

>>> design/clmd_window.sv
module clmd_window #(
  parameter int KMAX    = 15,
  parameter int KW      = 4,
  parameter int EXT_MAX = 7
) (
  input  logic              clk,
  input  logic              step,
  input  logic              first,
  input  logic [KW-1:0]     tag,
  input  logic [KW-1:0]     target,
  input  logic [KW-1:0]     k_eff,
  input  logic [KW-1:0]     ext,
  input  clmd_pkg::cm_rsp_t rsp,
  output logic              mask_bit
);

  localparam int CDN = EXT_MAX + 1;

  logic [KMAX-1:0] hv;
  logic [KW-1:0]   htag [KMAX];
  logic [1:0]      cd [CDN];

  logic [KMAX-1:0] nv;
  logic [KW-1:0]   ntag [KMAX];
  logic [1:0]      ncd [CDN];
  logic            dil;
  logic [1:0]      own;

  always_comb begin
    nv[0]   = rsp.vhit;
    ntag[0] = tag;
    for (int t = 1; t < KMAX; t++) begin
      nv[t]   = first ? 1'b0 : hv[t-1];
      ntag[t] = htag[t-1];
    end
    dil = 1'b0;
    for (int t = 0; t < KMAX; t++) begin
      if ((t < 32'(k_eff)) && nv[t] && (ntag[t] == target)) begin
        dil = 1'b1;
      end
    end
    ncd[0] = {rsp.own_color, rsp.own_gray};
    for (int t = 1; t < CDN; t++) begin
      ncd[t] = cd[t-1];
    end
    own = ncd[0];
    for (int t = 1; t < CDN; t++) begin
      if (32'(ext) == t) begin
        own = ncd[t];
      end
    end
    mask_bit = (own[1] | dil) & own[0];
  end

  always_ff @(posedge clk) begin
    if (step) begin
      hv <= nv;
      for (int t = 0; t < KMAX; t++) begin
        htag[t] <= ntag[t];
      end
      for (int t = 0; t < CDN; t++) begin
        cd[t] <= ncd[t];
      end
    end
  end

endmodule

>>> design/clmd_out_fifo.sv
module clmd_out_fifo (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  clmd_pkg::out_item_t    din,
  input  logic                   pop,
  output logic                   valid,
  output clmd_pkg::out_item_t    dout,
  output clmd_pkg::fifo_stat_t   stat
);

  clmd_pkg::out_item_t mem [clmd_pkg::FIFO_DEPTH];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [1:0] count;

  assign valid      = (count != 2'd0);
  assign dout       = mem[rd_ptr];
  assign stat.count = count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (32'(wr_ptr) == clmd_pkg::FIFO_DEPTH - 1) ? 2'd0 : wr_ptr + 2'd1;
      end
      if (pop) begin
        rd_ptr <= (32'(rd_ptr) == clmd_pkg::FIFO_DEPTH - 1) ? 2'd0 : rd_ptr + 2'd1;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

>>> design/color_light_mask_with_dilation.sv
// Color light mask with square dilation. Takes BGR pixels in raster order and returns one
// mask bit per pixel: the color bit dilated by a K x K square (seeds only ext = (K-1)/2 or
// more from every border) ANDed with the luma threshold bit. A result appears ext rows and
// ext columns after its pixel; once a frame is fully input, each further item (drain or
// pixel, whose data is dropped) pushes out one pending result, and tlast marks the last
// pixel of the frame. Sustained rate is one item per clock while the output queue has
// room: each item passes a registered read of the per-column memory, its read-modify-write
// (forwarding for back-to-back hits on the same column) and a 3-entry output queue. When a
// frame holds fewer pixels than that lag (ext * width + ext), s_tready drops once the frame
// is fully input while the pipeline steps on its own through each missing lag step. After
// reset a clearing pass over all MAX_WIDTH columns sets the column ages and holds s_tready
// low. Writes to the six defined configuration registers restart the frame position.
module color_light_mask_with_dilation #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_KERNEL = 15
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [clmd_pkg::S_TDATA_W-1:0]     s_tdata,   // blue, green, red
  input  logic                               s_tuser,   // drain
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [clmd_pkg::M_TDATA_W-1:0]     m_tdata,   // mask_bit, zero fill
  output logic                               m_tlast,   // frame_end
  input  logic                               cfg_we,
  input  logic [clmd_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [clmd_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int EXT_MAX = (MAX_KERNEL - 1) / 2;
  localparam int KW  = $clog2(MAX_KERNEL + 1);
  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int OHW = $clog2(MAX_HEIGHT);
  localparam int RW  = $clog2(MAX_HEIGHT + EXT_MAX + 2);
  localparam int LW  = $clog2(EXT_MAX * MAX_WIDTH + EXT_MAX + 2);

  logic [10:0] frame_width;
  logic [10:0] frame_height;
  logic [3:0]  kernel_size;
  logic [7:0]  color_threshold;
  logic [7:0]  gray_threshold;
  logic        target_blue;

  logic [CW-1:0]  vcol, vcol_next;
  logic [RW-1:0]  vrow, vrow_next;
  logic [LW-1:0]  prime, prime_next;
  logic [CW-1:0]  out_col, out_col_next;
  logic [OHW-1:0] out_row, out_row_next;

  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic [KW-1:0] k_clip, k_eff, ext;
  logic [LW-1:0] lag;

  logic        acc, in_done, pos, pad, step, emit, last, restart, first;
  logic [7:0]  blue, green, red, diff;
  logic [22:0] luma_sum;
  logic        cbit, gbit, seed;

  logic          s1_valid, s1_emit, s1_last, s1_first;
  logic [KW-1:0] s1_tag, s1_target;

  clmd_pkg::cm_req_t    req;
  clmd_pkg::cm_rsp_t    rsp;
  clmd_pkg::fifo_stat_t fstat;
  clmd_pkg::out_item_t  fin, fout;
  logic                 clearing, mask_bit, push, pop;

  always_comb begin
    if (frame_width == 11'd0) begin
      w_eff = WW'(1);
    end else if (32'(frame_width) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(frame_width);
    end
    if (frame_height == 11'd0) begin
      h_eff = HW'(1);
    end else if (32'(frame_height) > MAX_HEIGHT) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(frame_height);
    end
    k_clip = (32'(kernel_size) > MAX_KERNEL) ? KW'(MAX_KERNEL) : KW'(kernel_size);
    k_eff  = (k_clip == '0) ? KW'(1) : k_clip;
    ext    = (k_eff - KW'(1)) >> 1;
    lag    = LW'(32'(ext) * 32'(w_eff) + 32'(ext));
  end

  assign blue  = s_tdata[7:0];
  assign green = s_tdata[15:8];
  assign red   = s_tdata[23:16];

  always_comb begin
    if (target_blue) begin
      diff = (blue > red) ? blue - red : 8'd0;
    end else begin
      diff = (red > blue) ? red - blue : 8'd0;
    end
    luma_sum = 23'(blue) * clmd_pkg::LUMA_B + 23'(green) * clmd_pkg::LUMA_G
             + 23'(red) * clmd_pkg::LUMA_R + clmd_pkg::LUMA_ROUND;
  end

  assign acc     = s_tvalid && s_tready;
  assign in_done = 32'(vrow) >= 32'(h_eff);
  assign pos     = acc && (in_done || !s_tuser);
  assign pad     = !clearing && in_done && (prime != lag);
  assign step    = pos || pad;
  assign emit    = pos && (in_done || (prime == lag));
  assign first   = (vcol == '0) && (vrow == '0);
  assign restart = cfg_we && (32'(cfg_addr) < clmd_pkg::CFG_COUNT);

  assign cbit = !in_done && (diff > color_threshold);
  assign gbit = !in_done && (luma_sum[22:clmd_pkg::LUMA_SHIFT] > {1'b0, gray_threshold});
  assign seed = cbit && (32'(vrow) >= 32'(ext)) && (32'(vrow) + 32'(ext) < 32'(h_eff))
             && (32'(vcol) >= 32'(ext)) && (32'(vcol) + 32'(ext) < 32'(w_eff));

  always_comb begin
    vcol_next    = vcol;
    vrow_next    = vrow;
    prime_next   = prime;
    out_col_next = out_col;
    out_row_next = out_row;
    last         = 1'b0;
    if (step) begin
      if (32'(vcol) + 1 >= 32'(w_eff)) begin
        vcol_next = '0;
        vrow_next = vrow + RW'(1);
      end else begin
        vcol_next = vcol + CW'(1);
      end
      if (prime != lag) begin
        prime_next = prime + LW'(1);
      end
    end
    if (emit) begin
      if (32'(out_col) + 1 >= 32'(w_eff)) begin
        out_col_next = '0;
        if (32'(out_row) + 1 >= 32'(h_eff)) begin
          last = 1'b1;
        end else begin
          out_row_next = out_row + OHW'(1);
        end
      end else begin
        out_col_next = out_col + CW'(1);
      end
    end
    if (last || restart) begin
      vcol_next    = '0;
      vrow_next    = '0;
      prime_next   = '0;
      out_col_next = '0;
      out_row_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width     <= clmd_pkg::RST_FRAME_WIDTH;
      frame_height    <= clmd_pkg::RST_FRAME_HEIGHT;
      kernel_size     <= clmd_pkg::RST_KERNEL_SIZE;
      color_threshold <= clmd_pkg::RST_COLOR_THR;
      gray_threshold  <= clmd_pkg::RST_GRAY_THR;
      target_blue     <= clmd_pkg::RST_TARGET_BLUE;
      vcol     <= '0;
      vrow     <= '0;
      prime    <= '0;
      out_col  <= '0;
      out_row  <= '0;
      s1_valid <= 1'b0;
      s1_emit  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (clmd_pkg::cfg_idx_t'(cfg_addr))
          clmd_pkg::CFG_FRAME_WIDTH:     frame_width     <= cfg_data;
          clmd_pkg::CFG_FRAME_HEIGHT:    frame_height    <= cfg_data;
          clmd_pkg::CFG_KERNEL_SIZE:     kernel_size     <= cfg_data[3:0];
          clmd_pkg::CFG_COLOR_THRESHOLD: color_threshold <= cfg_data[7:0];
          clmd_pkg::CFG_GRAY_THRESHOLD:  gray_threshold  <= cfg_data[7:0];
          clmd_pkg::CFG_TARGET_BLUE:     target_blue     <= cfg_data[0];
          default: ;
        endcase
      end
      vcol     <= vcol_next;
      vrow     <= vrow_next;
      prime    <= prime_next;
      out_col  <= out_col_next;
      out_row  <= out_row_next;
      s1_valid <= step;
      s1_emit  <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      s1_last   <= last;
      s1_first  <= first;
      s1_tag    <= KW'(vrow);
      s1_target <= KW'(32'(out_row) + 32'(ext));
    end
  end

  assign req.color = cbit;
  assign req.gray  = gbit;
  assign req.seed  = seed;

  clmd_column_mem #(
    .DEPTH   (MAX_WIDTH),
    .RW      (RW),
    .KW      (KW),
    .EXT_MAX (EXT_MAX)
  ) u_column_mem (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (step),
    .rd_addr  (vcol),
    .req      (req),
    .row      (vrow),
    .k_eff    (k_eff),
    .ext      (ext),
    .rsp      (rsp),
    .clearing (clearing)
  );

  clmd_window #(
    .KMAX    (MAX_KERNEL),
    .KW      (KW),
    .EXT_MAX (EXT_MAX)
  ) u_window (
    .clk      (clk),
    .step     (s1_valid),
    .first    (s1_first),
    .tag      (s1_tag),
    .target   (s1_target),
    .k_eff    (k_eff),
    .ext      (ext),
    .rsp      (rsp),
    .mask_bit (mask_bit)
  );

  assign push          = s1_valid && s1_emit;
  assign pop           = m_tvalid && m_tready;
  assign fin.mask_bit  = mask_bit;
  assign fin.frame_end = s1_last;

  clmd_out_fifo u_out_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (fin),
    .pop   (pop),
    .valid (m_tvalid),
    .dout  (fout),
    .stat  (fstat)
  );

  assign s_tready = !clearing && !pad
                 && (32'(fstat.count) + 32'(push) < clmd_pkg::FIFO_DEPTH);
  assign m_tdata  = clmd_pkg::M_TDATA_W'(fout.mask_bit);
  assign m_tlast  = fout.frame_end;

  a_fifo_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |-> (32'(fstat.count) < clmd_pkg::FIFO_DEPTH))
    else $error("output queue overflow");

  a_frame_end_restart: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_last) |-> (vcol == '0 && vrow == '0 && out_row == '0 && out_col == '0))
    else $error("position not restarted at frame end");

  a_out_row_range: assert property (@(posedge clk) disable iff (rst)
    32'(out_row) < 32'(h_eff))
    else $error("output row out of frame");

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int MAXW = 1024;
  localparam int MAXH = 1024;
  localparam int MAXK = 15;
  localparam int RING = MAXK + 2;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE = 40;
  localparam int AW = clmd_pkg::CFG_ADDR_W;
  localparam int DW = clmd_pkg::CFG_DATA_W;
  localparam logic [AW-1:0] IDX_SPARE_LO = AW'(clmd_pkg::CFG_COUNT);
  localparam logic [AW-1:0] IDX_SPARE_HI = AW'(clmd_pkg::CFG_COUNT + 1);

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [clmd_pkg::S_TDATA_W-1:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [clmd_pkg::M_TDATA_W-1:0] m_tdata;
  logic m_tlast;
  logic cfg_we = 1'b0;
  logic [AW-1:0] cfg_addr = '0;
  logic [DW-1:0] cfg_data = '0;

  color_light_mask_with_dilation dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mirror of the block's registers and line stores
  logic [10:0] width_reg, height_reg;
  logic [3:0] ksize_reg;
  logic [7:0] cthr_reg, gthr_reg;
  logic blue_reg;
  bit color_mem[RING][MAXW];
  bit gray_mem[RING][MAXW];
  int in_row, in_col, out_row, out_col;

  clmd_pkg::out_item_t mask_queue[$];
  int errors = 0;
  int items_sent = 0;
  int cycles = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_cycles = 0;
  bit frame_closed;

  function automatic int eff_w();
    if (width_reg == 0) return 1;
    return width_reg > MAXW ? MAXW : int'(width_reg);
  endfunction

  function automatic int eff_h();
    if (height_reg == 0) return 1;
    return height_reg > MAXH ? MAXH : int'(height_reg);
  endfunction

  function automatic int eff_ext();
    return ksize_reg == 0 ? 0 : (int'(ksize_reg) - 1) / 2;
  endfunction

  function automatic bit seed_at(int i, int j, int w, int h, int ext);
    if (i < ext || i >= h - ext || j < ext || j >= w - ext) return 1'b0;
    return color_mem[i % RING][j];
  endfunction

  function automatic bit dilated_bit(int pr, int pc, int w, int h);
    int k;
    int ext;
    bit hit;
    k = ksize_reg;
    ext = eff_ext();
    hit = color_mem[pr % RING][pc];
    if (k > 0)
      for (int i = pr + ext - k + 1; i <= pr + ext && !hit; i++)
        for (int j = pc + ext - k + 1; j <= pc + ext && !hit; j++)
          if (seed_at(i, j, w, h, ext)) hit = 1'b1;
    return hit && gray_mem[pr % RING][pc];
  endfunction

  function automatic void predict_mask(bit drain, logic [7:0] b, logic [7:0] g,
                                       logic [7:0] r);
    int w;
    int h;
    int ext;
    int diff;
    int luma;
    bit emit;
    clmd_pkg::out_item_t res;
    w = eff_w();
    h = eff_h();
    ext = eff_ext();
    emit = 1'b0;
    if (in_row >= h) begin
      emit = 1'b1;
    end else if (!drain) begin
      if (blue_reg) diff = b > r ? b - r : 0;
      else diff = r > b ? r - b : 0;
      luma = (1868 * b + 9617 * g + 4899 * r + 8192) >> 14;
      color_mem[in_row % RING][in_col] = diff > cthr_reg;
      gray_mem[in_row % RING][in_col] = luma > gthr_reg;
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
      end
      emit = (in_row * w + in_col) - (out_row * w + out_col) > ext * w + ext;
    end
    if (!emit) return;
    res.mask_bit = dilated_bit(out_row, out_col, w, h);
    res.frame_end = 1'b0;
    out_col++;
    if (out_col >= w) begin
      out_col = 0;
      out_row++;
    end
    if (out_row >= h) begin
      res.frame_end = 1'b1;
      frame_closed = 1'b1;
      in_row = 0;
      in_col = 0;
      out_row = 0;
      out_col = 0;
    end
    mask_queue.push_back(res);
  endfunction

  task automatic write_reg(logic [AW-1:0] idx, logic [DW-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      clmd_pkg::CFG_FRAME_WIDTH: width_reg = val;
      clmd_pkg::CFG_FRAME_HEIGHT: height_reg = val;
      clmd_pkg::CFG_KERNEL_SIZE: ksize_reg = val[3:0];
      clmd_pkg::CFG_COLOR_THRESHOLD: cthr_reg = val[7:0];
      clmd_pkg::CFG_GRAY_THRESHOLD: gthr_reg = val[7:0];
      clmd_pkg::CFG_TARGET_BLUE: blue_reg = val[0];
      default: return;
    endcase
    in_row = 0;
    in_col = 0;
    out_row = 0;
    out_col = 0;
  endtask

  task automatic wait_idle();
    while (mask_queue.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic configure(int w, int h, int k, int ct, int gt, bit tb);
    wait_idle();
    write_reg(clmd_pkg::CFG_FRAME_WIDTH, DW'(w));
    write_reg(clmd_pkg::CFG_FRAME_HEIGHT, DW'(h));
    write_reg(clmd_pkg::CFG_KERNEL_SIZE, DW'(k));
    write_reg(clmd_pkg::CFG_COLOR_THRESHOLD, DW'(ct));
    write_reg(clmd_pkg::CFG_GRAY_THRESHOLD, DW'(gt));
    write_reg(clmd_pkg::CFG_TARGET_BLUE, DW'(tb));
  endtask

  task automatic send_item(bit drain, logic [7:0] b, logic [7:0] g, logic [7:0] r);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser <= drain;
    s_tdata <= {r, g, b};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_mask(drain, b, g, r);
    items_sent++;
  endtask

  task automatic release_bus();
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  task automatic send_pixel();
    logic [7:0] b;
    logic [7:0] r;
    case ($urandom_range(2))
      0: begin
        b = 8'($urandom_range(255, 120));
        r = 8'($urandom_range(60));
      end
      1: begin
        r = 8'($urandom_range(255, 120));
        b = 8'($urandom_range(60));
      end
      default: begin
        b = 8'($urandom);
        r = 8'($urandom);
      end
    endcase
    send_item(1'b0, b, 8'($urandom), r);
  endtask

  // full frame with random content, stray drains inside, mixed flush items
  task automatic run_frame(int noise_pct);
    int n;
    n = eff_w() * eff_h();
    frame_closed = 1'b0;
    for (int p = 0; p < n; p++) begin
      if ($urandom_range(99) < noise_pct)
        send_item(1'b1, 8'($urandom), 8'($urandom), 8'($urandom));
      send_pixel();
    end
    while (!frame_closed) begin
      if ($urandom_range(99) < noise_pct) send_pixel();
      else send_item(1'b1, 8'($urandom), 8'($urandom), 8'($urandom));
    end
    release_bus();
  endtask

  task automatic test_pixel_extremes();
    configure(5, 5, 3, 0, 0, 1'b1);
    frame_closed = 1'b0;
    send_item(1'b0, 8'd0, 8'd0, 8'd0);
    send_item(1'b0, 8'd255, 8'd255, 8'd255);
    send_item(1'b0, 8'd255, 8'd0, 8'd0);
    send_item(1'b0, 8'd0, 8'd0, 8'd255);
    send_item(1'b0, 8'd255, 8'd255, 8'd0);
    send_item(1'b1, 8'd0, 8'd0, 8'd0);
    for (int p = 0; p < 20; p++) send_item(1'b0, 8'd255, 8'd255, 8'd1);
    while (!frame_closed) send_item(1'b0, 8'd7, 8'd7, 8'd7);
    release_bus();
    configure(4, 4, 0, 255, 255, 1'b0);
    run_frame(20);
    configure(6, 6, 15, 0, 0, 1'b0);
    run_frame(20);
  endtask

  task automatic test_frame_limits();
    configure(0, 0, 3, 50, 40, 1'b1);
    run_frame(30);
    configure(1, 9, 5, 60, 60, 1'b0);
    run_frame(0);
    configure(9, 1, 2, 80, 80, 1'b1);
    run_frame(0);
    wait_idle();
    write_reg(IDX_SPARE_LO, 11'h7ff);
    write_reg(IDX_SPARE_HI, 11'h000);
    run_frame(10);
  endtask

  task automatic test_kernels();
    for (int k = 0; k < 16; k++) begin
      configure($urandom_range(8, 1), $urandom_range(6, 1), k, $urandom_range(120),
                $urandom_range(120), 1'($urandom_range(1)));
      run_frame(10);
    end
  endtask

  task automatic test_random_phase(int ipct, int spct, int item_goal);
    wait_idle();
    idle_pct = ipct;
    stall_pct = spct;
    while (items_sent < item_goal) begin
      configure($urandom_range(16, 1), $urandom_range(8, 1), $urandom_range(15),
                $urandom_range(150), $urandom_range(160), 1'($urandom_range(1)));
      run_frame(8);
    end
  endtask

  task automatic test_backpressure();
    configure(20, 8, 5, 40, 40, 1'b1);
    idle_pct = 0;
    stall_pct = 0;
    hold_cycles = 300;
    run_frame(0);
  endtask

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= $urandom_range(99) >= stall_pct;
    end
  end

  always @(posedge clk) begin
    clmd_pkg::out_item_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (mask_queue.size() == 0) begin
        $error("unexpected transfer mask_bit=%0b frame_end=%0b", m_tdata[0], m_tlast);
        errors++;
      end else begin
        want = mask_queue.pop_front();
        if (m_tdata[0] !== want.mask_bit) begin
          $error("mask_bit expected %0b actual %0b", want.mask_bit, m_tdata[0]);
          errors++;
        end
        if (m_tlast !== want.frame_end) begin
          $error("frame_end expected %0b actual %0b", want.frame_end, m_tlast);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  initial begin
    width_reg = clmd_pkg::RST_FRAME_WIDTH;
    height_reg = clmd_pkg::RST_FRAME_HEIGHT;
    ksize_reg = clmd_pkg::RST_KERNEL_SIZE;
    cthr_reg = clmd_pkg::RST_COLOR_THR;
    gthr_reg = clmd_pkg::RST_GRAY_THR;
    blue_reg = clmd_pkg::RST_TARGET_BLUE;
    in_row = 0;
    in_col = 0;
    out_row = 0;
    out_col = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_pixel_extremes();
    test_frame_limits();
    test_kernels();
    test_backpressure();
    test_random_phase(0, 0, items_sent + 130);
    test_random_phase(52, 0, items_sent + 130);
    test_random_phase(0, 52, items_sent + 130);
    test_random_phase(10, 10, items_sent + 130);
    wait_idle();
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

>>> color_light_mask_with_dilation.f
design/clmd_pkg.sv
design/clmd_column_mem.sv
design/clmd_window.sv
design/clmd_out_fifo.sv
design/color_light_mask_with_dilation.sv
test/tb_top.sv
